// ----- hdl/bsme_pkg.sv -----
package bsme_pkg;

  localparam int DATA_W    = 32;
  localparam int CAP_W     = 9;
  localparam int DEPTH_DEF = 256;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // request codes (in_tuser); code 3 is unused and returns ok / zero
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_FIND = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NOEVEN = 2'd3
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] value;
  } result_t;

endpackage

// ----- hdl/bsme_engine.sv -----
module bsme_engine #(
  parameter int DEPTH = bsme_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [1:0]                   req,
  input  logic [bsme_pkg::DATA_W-1:0]  push_value,
  input  logic [bsme_pkg::CAP_W-1:0]   capacity,
  output logic                         res_valid,
  input  logic                         res_ready,
  output bsme_pkg::result_t            res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW = (CW > bsme_pkg::CAP_W) ? CW : bsme_pkg::CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  logic signed [bsme_pkg::DATA_W-1:0] best_r, best_nxt;
  logic                          found_r, found_nxt;
  bsme_pkg::result_t             res_r, res_nxt;

  logic [bsme_pkg::DATA_W-1:0]   mem_r [DEPTH];
  logic [bsme_pkg::DATA_W-1:0]   rd_data_r;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;

  logic [CW-1:0]                 cnt_m1;
  logic [AW-1:0]                 top_addr;
  logic                          full;
  logic                          empty;
  logic                          take;
  logic signed [bsme_pkg::DATA_W-1:0] best_now;
  logic                          found_now;

  assign cnt_m1   = count_r - CW'(1);
  assign top_addr = cnt_m1[AW-1:0];
  assign full     = (count_r == CW'(DEPTH)) || (MW'(count_r) >= MW'(capacity));
  assign empty    = (count_r == '0);

  // shared compare: even and above the best so far
  assign take      = !rd_data_r[0] && (!found_r || ($signed(rd_data_r) > best_r));
  assign best_now  = take ? $signed(rd_data_r) : best_r;
  assign found_now = found_r || take;

  assign in_tready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    rd_addr   = top_addr;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DONE;
          res_nxt   = '{status: bsme_pkg::ST_OK, value: '0};
          case (req)
            bsme_pkg::REQ_PUSH: begin
              if (full) begin
                res_nxt.status = bsme_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            bsme_pkg::REQ_POP: begin
              if (empty) begin
                res_nxt.status = bsme_pkg::ST_EMPTY;
              end else begin
                count_nxt = cnt_m1;
                state_nxt = S_POP;
              end
            end
            bsme_pkg::REQ_FIND: begin
              if (empty) begin
                res_nxt.status = bsme_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = top_addr;
                best_nxt  = '0;
                found_nxt = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        res_nxt   = '{status: bsme_pkg::ST_OK, value: rd_data_r};
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        best_nxt  = best_now;
        found_nxt = found_now;
        if (idx_r != '0) begin
          idx_nxt = idx_r - AW'(1);
          rd_addr = idx_r - AW'(1);
        end else begin
          state_nxt = S_DONE;
          if (found_now) begin
            res_nxt = '{status: bsme_pkg::ST_OK, value: best_now};
          end else begin
            res_nxt = '{status: bsme_pkg::ST_NOEVEN, value: '0};
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
    end
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
    res_r  <= res_nxt;
  end

  // entry store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[count_r[AW-1:0]] <= push_value;
    end
    rd_data_r <= mem_r[rd_addr];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_tvalid && req == bsme_pkg::REQ_PUSH && !full)
      |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted push did not grow the stack");

  a_scan_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> $stable(count_r))
    else $error("entry count moved during scan");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status != bsme_pkg::ST_OK) |-> res.value == '0)
    else $error("error result carries nonzero value");
`endif

endmodule

// ----- hdl/bounded_stack_max_even.sv -----
// Channel | Dir | Signals                            | Word
// in      | in  | in_tvalid/in_tready/in_tdata/tuser | push value, request kind
// out     | out | out_tvalid/out_tready/out_tdata/.. | result value, status
// cfg     | in  | cfg_valid/cfg_ready/cfg_data       | capacity (9 bits)
//
// Per word: push and unused code 3 go straight to the done state, pop passes a read
// state first, and a find walks one entry a cycle, as the entry store has one read port.
// Input is taken only while the sequencer is idle; a finished result moves to
// the output register, so the next word is taken while it waits there.
// Reset (rst_n low, synchronous): stack empty, capacity 256, output empty; the
// entry store is not cleared. The cfg port is always ready; write it only while idle.
module bounded_stack_max_even #(
  parameter int DEPTH = bsme_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bsme_pkg::DATA_W-1:0]   in_tdata,   // [31:0] push_value
  input  logic [1:0]                    in_tuser,   // [1:0] req_type
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bsme_pkg::DATA_W-1:0]   out_tdata,  // [31:0] result_value
  output logic [1:0]                    out_tuser,  // [1:0] status
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsme_pkg::CAP_W-1:0]    cfg_data    // [8:0] capacity
);

  logic [bsme_pkg::CAP_W-1:0]  capacity_r;
  logic                        out_tvalid_r;
  logic [bsme_pkg::DATA_W-1:0] out_tdata_r;
  logic [1:0]                  out_tuser_r;

  logic                        res_valid;
  logic                        res_ready;
  bsme_pkg::result_t           res;

  // output slot frees when empty or being drained this cycle
  assign res_ready = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;

  bsme_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req        (in_tuser),
    .push_value (in_tdata),
    .capacity   (capacity_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= bsme_pkg::CAP_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity_r <= cfg_data;
      end
      if (res_valid && res_ready) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (res_valid && res_ready) begin
      out_tdata_r <= res.value;
      out_tuser_r <= res.status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- test/bounded_stack_max_even_tb.sv -----
module bounded_stack_max_even_tb;

  // Geometry and run shape
  localparam int STACK_DEPTH   = bsme_pkg::DEPTH_DEF;
  localparam int DIR_ROWS      = 28;
  localparam int RAND_PHASES   = 11;
  localparam int PHASE_WORDS   = 170;
  // Longest operation is a find over a full stack.
  // Every word yields a result, so an empty queue means the block is idle.
  // These few cycles are only margin.
  localparam int SETTLE_CYCLES = 8;
  // Slowest legal run: ~2200 words, each a full-depth find plus worst gap and
  // stall. Limit is well above the length of that run.
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int MAX_PRINTS    = 40;

  // Request code 3 is unused: the block answers ok / zero and changes nothing
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

  // One row of the directed sequence. ROW_CAP rows carry a capacity in val.
  // has_exp marks rows whose result is written out by hand.
  typedef struct {
    row_kind_t                   kind;
    logic [1:0]                  req;
    logic [bsme_pkg::DATA_W-1:0] val;
    bit                          has_exp;
    bsme_pkg::status_t           st;
    logic [bsme_pkg::DATA_W-1:0] res;
  } dir_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [bsme_pkg::DATA_W-1:0] in_tdata;   // [31:0] push_value
  logic [1:0]                  in_tuser;   // [1:0] req_type
  logic                        out_tvalid;
  logic                        out_tready;
  logic [bsme_pkg::DATA_W-1:0] out_tdata;  // [31:0] result_value
  logic [1:0]                  out_tuser;  // [1:0] status
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [bsme_pkg::CAP_W-1:0]  cfg_data;   // [8:0] capacity

  // Mirror of the block's state, advanced once per accepted input word
  logic [bsme_pkg::DATA_W-1:0] mirror_mem [STACK_DEPTH];
  int unsigned                 mirror_count;
  logic [bsme_pkg::CAP_W-1:0]  mirror_cap;

  // Results still owed by the block, oldest first
  bsme_pkg::result_t pending_results [$];

  int                err_count   = 0;
  int                cycle_count = 0;
  int                results_seen = 0;
  // When set, neither side inserts idle cycles (burst stretches)
  bit                no_gaps = 1'b0;

  bounded_stack_max_even u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 4-unit clock: rising edges at 2, 6, 10, ...
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[cycle %0d, result %0d] mismatch: %s", cycle_count, results_seen, what);
  endtask

  // Applies one request to the mirror and returns the result the block owes.
  // Effective capacity saturates at the depth; zero capacity refuses every push.
  // Find walks all held entries and keeps the largest even one, signed compare.
  function automatic bsme_pkg::result_t stack_apply(
    input logic [1:0] req, input logic [bsme_pkg::DATA_W-1:0] val);
    bsme_pkg::result_t           r;
    int unsigned                 lim;
    bit                          found;
    logic [bsme_pkg::DATA_W-1:0] best;
    logic [bsme_pkg::DATA_W-1:0] e;
    r.status = bsme_pkg::ST_OK;
    r.value  = '0;
    lim      = (mirror_cap > STACK_DEPTH) ? STACK_DEPTH : mirror_cap;
    found    = 1'b0;
    best     = '0;
    case (req)
      bsme_pkg::REQ_PUSH: begin
        if (mirror_count >= lim) begin
          r.status = bsme_pkg::ST_FULL;
        end else begin
          mirror_mem[mirror_count] = val;
          mirror_count++;
        end
      end
      bsme_pkg::REQ_POP: begin
        if (mirror_count == 0) begin
          r.status = bsme_pkg::ST_EMPTY;
        end else begin
          mirror_count--;
          r.value = mirror_mem[mirror_count];
        end
      end
      bsme_pkg::REQ_FIND: begin
        if (mirror_count == 0) begin
          r.status = bsme_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < mirror_count; i++) begin
            e = mirror_mem[i];
            if (!e[0] && (!found || $signed(e) > $signed(best))) begin
              best  = e;
              found = 1'b1;
            end
          end
          if (found) r.value = best;
          else r.status = bsme_pkg::ST_NOEVEN;
        end
      end
      default: ;  // unused code: no state change, ok / zero
    endcase
    return r;
  endfunction

  // Push value mix: sign extremes, small values near zero, random with a
  // chosen share of odd values (drives the no-even case).
  function automatic logic [bsme_pkg::DATA_W-1:0] pick_value(input int odd_pct);
    logic [bsme_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 11))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h7FFF_FFFE;
      3: v = 32'h0000_0000;
      4: v = 32'hFFFF_FFFF;
      5: v = 32'hFFFF_FFFE;
      6: v = 32'($urandom_range(0, 15));
      7: v = -32'($urandom_range(1, 16));
      default: begin
        v    = $urandom;
        v[0] = ($urandom_range(0, 99) < odd_pct);
      end
    endcase
    return v;
  endfunction

  // Sends one word. The valid stays up across back-to-back words and is only
  // dropped when a gap is drawn, so it never gets two updates in one step.
  task automatic send_word(input logic [1:0] req,
                           input logic [bsme_pkg::DATA_W-1:0] val,
                           input bit has_exp, input bsme_pkg::result_t hand_res);
    int                gap;
    bsme_pkg::result_t pred;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // accepted at this edge: advance the mirror, queue what is owed
    pred = stack_apply(req, val);
    pending_results.push_back(has_exp ? hand_res : pred);
  endtask

  // Sender holds off until every owed result has come back
  task automatic wait_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity writes only happen with the block idle
  task automatic write_capacity(input logic [bsme_pkg::CAP_W-1:0] cap);
    wait_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror_cap = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall per word, then take and check against the
  // oldest owed result.
  initial begin
    int                stall;
    bsme_pkg::result_t want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d value %h",
                                out_tuser, out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_tuser, want.status));
        if (out_tdata !== want.value)
          flag_mismatch($sformatf("value %h, want %h", out_tdata, want.value));
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t                   dir_tab [DIR_ROWS];
    bsme_pkg::result_t          hand_res;
    logic [1:0]                 req;
    logic [bsme_pkg::CAP_W-1:0] cap;
    int                         roll;
    int                         push_pct;
    int                         pop_pct;
    int                         odd_pct;

    // every input known from time zero
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = bsme_pkg::REQ_PUSH;
    cfg_valid = 1'b0;
    cfg_data  = '0;

    mirror_count = 0;
    mirror_cap   = bsme_pkg::CAP_RESET;

    // Directed sequence: empty stack, unused code, sign extremes, INT_MIN held
    // as an ordinary value, no-even, zero capacity, capacity below the count.
    dir_tab = '{
      '{ROW_WORD, bsme_pkg::REQ_POP, 32'h0, 1'b1, bsme_pkg::ST_EMPTY, 32'h0},  // pop, empty
      '{ROW_WORD, bsme_pkg::REQ_FIND, 32'h0, 1'b1, bsme_pkg::ST_EMPTY, 32'h0}, // find, empty
      '{ROW_WORD, REQ_NONE, 32'hFFFF_FFFF, 1'b1, bsme_pkg::ST_OK, 32'h0},      // unused code
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'h8000_0000, 1'b1, bsme_pkg::ST_OK, 32'h0},
      '{ROW_WORD, bsme_pkg::REQ_FIND, 32'h0, 1'b1, bsme_pkg::ST_OK, 32'h8000_0000},
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'h7FFF_FFFF, 1'b1, bsme_pkg::ST_OK, 32'h0},
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'h0000_0001, 1'b1, bsme_pkg::ST_OK, 32'h0},
      '{ROW_WORD, bsme_pkg::REQ_FIND, 32'h0, 1'b1, bsme_pkg::ST_OK, 32'h8000_0000},
      '{ROW_WORD, bsme_pkg::REQ_POP, 32'h0, 1'b1, bsme_pkg::ST_OK, 32'h0000_0001},
      '{ROW_WORD, bsme_pkg::REQ_POP, 32'h0, 1'b1, bsme_pkg::ST_OK, 32'h7FFF_FFFF},
      '{ROW_WORD, bsme_pkg::REQ_POP, 32'h0, 1'b1, bsme_pkg::ST_OK, 32'h8000_0000},
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'hFFFF_FFFF, 1'b1, bsme_pkg::ST_OK, 32'h0},
      '{ROW_WORD, bsme_pkg::REQ_FIND, 32'h0, 1'b1, bsme_pkg::ST_NOEVEN, 32'h0}, // odd only
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'h7FFF_FFFE, 1'b1, bsme_pkg::ST_OK, 32'h0},
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'hFFFF_FFFE, 1'b1, bsme_pkg::ST_OK, 32'h0},
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'h0000_0000, 1'b0, bsme_pkg::ST_OK, 32'h0},
      '{ROW_WORD, bsme_pkg::REQ_FIND, 32'h0, 1'b0, bsme_pkg::ST_OK, 32'h0},
      '{ROW_CAP, bsme_pkg::REQ_PUSH, 32'd0, 1'b0, bsme_pkg::ST_OK, 32'h0},  // capacity 0
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'h5555_5555, 1'b1, bsme_pkg::ST_FULL, 32'h0},
      '{ROW_WORD, bsme_pkg::REQ_POP, 32'h0, 1'b0, bsme_pkg::ST_OK, 32'h0},
      '{ROW_CAP, bsme_pkg::REQ_PUSH, 32'd1, 1'b0, bsme_pkg::ST_OK, 32'h0},  // below count
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'hAAAA_AAAA, 1'b1, bsme_pkg::ST_FULL, 32'h0},
      '{ROW_WORD, bsme_pkg::REQ_FIND, 32'h0, 1'b0, bsme_pkg::ST_OK, 32'h0},
      '{ROW_WORD, bsme_pkg::REQ_POP, 32'h0, 1'b1, bsme_pkg::ST_OK, 32'hFFFF_FFFE},
      '{ROW_WORD, bsme_pkg::REQ_POP, 32'h0, 1'b1, bsme_pkg::ST_OK, 32'h7FFF_FFFE},
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'h1234_5678, 1'b1, bsme_pkg::ST_FULL, 32'h0}, // at cap
      '{ROW_WORD, bsme_pkg::REQ_POP, 32'h0, 1'b1, bsme_pkg::ST_OK, 32'hFFFF_FFFF},
      '{ROW_WORD, bsme_pkg::REQ_PUSH, 32'h1234_5678, 1'b1, bsme_pkg::ST_OK, 32'h0}
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_CAP) begin
        write_capacity(dir_tab[r].val[bsme_pkg::CAP_W-1:0]);
      end else begin
        hand_res.status = dir_tab[r].st;
        hand_res.value  = dir_tab[r].res;
        send_word(dir_tab[r].req, dir_tab[r].val, dir_tab[r].has_exp, hand_res);
      end
    end

    // Fill to the full depth under a capacity above it (saturation), push past
    // full, scan the whole stack, then check the exact-depth capacity.
    hand_res = '0;
    write_capacity(9'd511);
    while (mirror_count < STACK_DEPTH)
      send_word(bsme_pkg::REQ_PUSH, pick_value(50), 1'b0, hand_res);
    repeat (3) send_word(bsme_pkg::REQ_PUSH, pick_value(50), 1'b0, hand_res);
    send_word(bsme_pkg::REQ_FIND, 32'h0, 1'b0, hand_res);
    write_capacity(9'd256);
    send_word(bsme_pkg::REQ_PUSH, pick_value(50), 1'b0, hand_res);
    send_word(bsme_pkg::REQ_FIND, 32'h0, 1'b0, hand_res);

    // Random phases: each picks a capacity, a request mix (grow, shrink,
    // balanced), an odd-value share, and maybe a burst stretch.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 6)
        0: cap = 9'd1;
        1: cap = 9'd0;
        2: cap = 9'($urandom_range(2, 255));
        3: cap = 9'($urandom_range(257, 511));
        4: cap = 9'd2;
        default: cap = 9'd256;
      endcase
      write_capacity(cap);
      case ($urandom_range(0, 2))
        0: begin push_pct = 70; pop_pct = 12; end
        1: begin push_pct = 20; pop_pct = 60; end
        default: begin push_pct = 45; pop_pct = 35; end
      endcase
      case ($urandom_range(0, 2))
        0: odd_pct = 10;
        1: odd_pct = 90;
        default: odd_pct = 50;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) req = REQ_NONE;
        else if (roll < 3 + push_pct) req = bsme_pkg::REQ_PUSH;
        else if (roll < 3 + push_pct + pop_pct) req = bsme_pkg::REQ_POP;
        else req = bsme_pkg::REQ_FIND;
        send_word(req, pick_value(odd_pct), 1'b0, hand_res);
        // occasional mid-phase drain
        if ($urandom_range(0, 149) == 0) wait_quiet();
      end
      no_gaps = 1'b0;
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
